FILE: rtl/hsc_pkg.sv
package hsc_pkg;

	localparam int WINDOW_DEPTH = 32;
	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_W = 34;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [2:0] GRIP_OPEN = 3'd2;
	localparam logic [2:0] GRIP_CLOSED = 3'd3;

	localparam logic [2:0] DIR_NONE = 3'd0;
	localparam logic [2:0] DIR_LEFT = 3'd1;
	localparam logic [2:0] DIR_RIGHT = 3'd2;
	localparam logic [2:0] DIR_UP = 3'd3;
	localparam logic [2:0] DIR_DOWN = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_MIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_MAX = 2'd3;

	localparam logic [31:0] WINDOW_RESET = 32'd500000;
	localparam logic [14:0] THRESHOLD_RESET = 15'd819;
	localparam logic [31:0] CLICK_MIN_RESET = 32'd100000;
	localparam logic [31:0] CLICK_MAX_RESET = 32'd200000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EV_RD,
		S_EV_CMP,
		S_SCAN,
		S_DIR,
		S_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_WAIT_OPEN,
		PH_WAIT_CLOSED,
		PH_WAIT_REOPEN,
		PH_HIT
	} click_phase_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [2:0] grip;
	} entry_t;

	typedef struct packed {
		logic [31:0] window_ticks;
		logic [14:0] move_threshold;
		logic [31:0] click_min_ticks;
		logic [31:0] click_max_ticks;
	} cfg_t;

	typedef struct packed {
		logic wr_en;
		logic [PTR_W-1:0] wr_addr;
		entry_t wr_data;
		logic rd_en;
		logic [PTR_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic [2:0] direction;
		logic clicked;
	} res_t;

endpackage

FILE: rtl/hsc_if.sv
interface hsc_sample_if;
	logic valid;
	logic ready;
	logic [31:0] stamp;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [2:0] grip;

	modport source (output valid, stamp, pos_x, pos_y, grip, input ready);
	modport sink (input valid, stamp, pos_x, pos_y, grip, output ready);
endinterface

interface hsc_result_if;
	logic valid;
	logic ready;
	logic [2:0] direction;
	logic clicked;

	modport source (output valid, direction, clicked, input ready);
	modport sink (input valid, direction, clicked, output ready);
endinterface

interface hsc_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/hsc_window.sv
module hsc_window
	import hsc_pkg::*;
(
	input logic clk,
	input mem_req_t req,
	output entry_t rd_data_q
);

	entry_t mem_q [WINDOW_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

endmodule

FILE: rtl/hsc_cmp.sv
module hsc_cmp
	import hsc_pkg::*;
(
	input logic signed [CMP_W-1:0] op_a,
	input logic signed [CMP_W-1:0] op_b,
	output logic gt
);

	// shared signed magnitude compare, used for age and displacement tests
	assign gt = op_a > op_b;

endmodule

FILE: rtl/hsc_seq.sv
module hsc_seq
	import hsc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic smp_valid,
	output logic smp_ready,
	input entry_t smp,
	output mem_req_t mem_req,
	input entry_t mem_rd,
	input logic out_free,
	output logic res_load,
	output res_t res
);

	seq_state_t state_q, state_nxt;

	logic [PTR_W-1:0] oldest_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] prc_q;
	logic [CNT_W-1:0] opens_q;
	logic rd_vld_s1;
	click_phase_t phase_q;
	logic [31:0] start_q;
	logic [31:0] now_q;
	logic signed [15:0] nx_q, ny_q, fx_q, fy_q;
	logic [2:0] dir_q;
	logic [1:0] dir_idx_q;

	logic accept;
	logic issue;
	logic last_prc;
	logic share_ok;
	logic [31:0] age;
	logic [31:0] span;
	logic span_ok;
	logic signed [16:0] dx, dy;
	logic signed [CMP_W-1:0] dx_w, dy_w, thr_w, neg_thr_w;
	logic signed [CMP_W-1:0] op_a, op_b;
	logic cmp_gt;
	logic [2:0] dir_code;

	assign accept = smp_valid && smp_ready;
	assign issue = (state_q == S_SCAN) && (iss_q < fill_q);
	assign last_prc = rd_vld_s1 && (prc_q == fill_q - CNT_W'(1));
	assign share_ok = (fill_q > CNT_W'(1)) &&
		(({3'b0, opens_q} * 9'd5) > ({3'b0, fill_q} * 9'd4));
	assign age = now_q - mem_rd.stamp;
	assign span = mem_rd.stamp - start_q;
	assign span_ok = (span > cfg.click_min_ticks) && (span < cfg.click_max_ticks);
	assign dx = 17'(nx_q) - 17'(fx_q);
	assign dy = 17'(ny_q) - 17'(fy_q);
	assign dx_w = CMP_W'(dx);
	assign dy_w = CMP_W'(dy);
	assign thr_w = $signed({{(CMP_W - 15){1'b0}}, cfg.move_threshold});
	assign neg_thr_w = -thr_w;

	hsc_cmp u_cmp (
		.op_a(op_a),
		.op_b(op_b),
		.gt(cmp_gt)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (smp_valid) state_nxt = S_EV_RD;
			end
			S_EV_RD: begin
				state_nxt = (fill_q > CNT_W'(1)) ? S_EV_CMP : S_SCAN;
			end
			S_EV_CMP: begin
				state_nxt = cmp_gt ? S_EV_RD : S_SCAN;
			end
			S_SCAN: begin
				if (last_prc) state_nxt = S_DIR;
			end
			S_DIR: begin
				if (!share_ok || cmp_gt || dir_idx_q == 2'd3) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs and shared unit operands
	always_comb begin
		smp_ready = (state_q == S_IDLE);
		res_load = (state_q == S_DONE) && out_free;
		res.direction = dir_q;
		res.clicked = (dir_q == DIR_NONE) && (phase_q == PH_HIT);

		mem_req.wr_en = accept;
		mem_req.wr_addr = oldest_q + fill_q[PTR_W-1:0];
		mem_req.wr_data = smp;
		mem_req.rd_en = ((state_q == S_EV_RD) && (fill_q > CNT_W'(1))) || issue;
		mem_req.rd_addr = (state_q == S_EV_RD) ? oldest_q : oldest_q + iss_q[PTR_W-1:0];

		op_a = $signed({2'b00, age});
		op_b = $signed({2'b00, cfg.window_ticks});
		dir_code = DIR_NONE;
		if (state_q == S_DIR) begin
			case (dir_idx_q)
				2'd0: begin
					op_a = neg_thr_w;
					op_b = dx_w;
					dir_code = DIR_LEFT;
				end
				2'd1: begin
					op_a = dx_w;
					op_b = thr_w;
					dir_code = DIR_RIGHT;
				end
				2'd2: begin
					op_a = neg_thr_w;
					op_b = dy_w;
					dir_code = DIR_UP;
				end
				2'd3: begin
					op_a = dy_w;
					op_b = thr_w;
					dir_code = DIR_DOWN;
				end
				default: begin
					op_a = dx_w;
					op_b = thr_w;
					dir_code = DIR_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			oldest_q <= '0;
			fill_q <= '0;
			iss_q <= '0;
			prc_q <= '0;
			opens_q <= '0;
			rd_vld_s1 <= 1'b0;
			phase_q <= PH_WAIT_OPEN;
			dir_q <= DIR_NONE;
			dir_idx_q <= '0;
		end else begin
			state_q <= state_nxt;
			rd_vld_s1 <= issue;

			if (accept) begin
				// full ring: the new entry lands on the oldest slot
				if (fill_q == CNT_W'(WINDOW_DEPTH)) begin
					oldest_q <= oldest_q + PTR_W'(1);
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end

			if (state_q == S_EV_CMP && cmp_gt) begin
				oldest_q <= oldest_q + PTR_W'(1);
				fill_q <= fill_q - CNT_W'(1);
			end

			if (state_nxt == S_SCAN && state_q != S_SCAN) begin
				iss_q <= '0;
				prc_q <= '0;
				opens_q <= '0;
				phase_q <= PH_WAIT_OPEN;
			end

			if (issue) iss_q <= iss_q + CNT_W'(1);

			if (state_q == S_SCAN && rd_vld_s1) begin
				prc_q <= prc_q + CNT_W'(1);
				if (mem_rd.grip == GRIP_OPEN) opens_q <= opens_q + CNT_W'(1);
				case (phase_q)
					PH_WAIT_OPEN: begin
						if (mem_rd.grip == GRIP_OPEN) phase_q <= PH_WAIT_CLOSED;
					end
					PH_WAIT_CLOSED: begin
						if (mem_rd.grip == GRIP_CLOSED) phase_q <= PH_WAIT_REOPEN;
					end
					PH_WAIT_REOPEN: begin
						if (mem_rd.grip == GRIP_OPEN && span_ok) phase_q <= PH_HIT;
					end
					default: phase_q <= phase_q;
				endcase
			end

			if (state_q == S_SCAN && state_nxt == S_DIR) begin
				dir_idx_q <= '0;
				dir_q <= DIR_NONE;
			end

			if (state_q == S_DIR && share_ok) begin
				dir_idx_q <= dir_idx_q + 2'd1;
				if (cmp_gt) dir_q <= dir_code;
			end

			if (res_load && (dir_q != DIR_NONE || phase_q == PH_HIT)) begin
				fill_q <= '0;
				oldest_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= smp.stamp;
			nx_q <= smp.pos_x;
			ny_q <= smp.pos_y;
		end
		if (state_q == S_SCAN && rd_vld_s1) begin
			if (prc_q == '0) begin
				fx_q <= mem_rd.pos_x;
				fy_q <= mem_rd.pos_y;
			end
			if (phase_q == PH_WAIT_CLOSED && mem_rd.grip == GRIP_CLOSED) begin
				start_q <= mem_rd.stamp;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_DEPTH))
		else $error("window fill count above depth");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DIR) |-> fill_q != '0)
		else $error("scan over an empty window");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 && state_q == S_SCAN |-> prc_q < fill_q)
		else $error("scan processes an entry beyond the fill count");

	a_load_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> state_q == S_IDLE && !$past(smp_ready))
		else $error("result load did not return to idle");

	a_clear_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && (res.direction != DIR_NONE || res.clicked) |=> fill_q == '0)
		else $error("window not cleared after swipe or click");

endmodule

FILE: rtl/hand_swipe_click_detector.sv
// Hand swipe and click detector. Every accepted sample gives exactly one
// result (direction, clicked) on the result channel. For each sample the
// block ages out old entries, walks the entries left in the 32-entry window
// (at most 32) and runs up to four direction tests, reading one entry at a
// time from the window memory, which has one write and one read port. The
// sample channel is not ready while a sample is being worked on; a finished
// result waits in an output register while the next sample is taken.
// Configuration writes are always ready and should only be issued while the
// block is idle.
module hand_swipe_click_detector
	import hsc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	hsc_sample_if.sink sample_ch,
	hsc_result_if.source result_ch,
	hsc_cfg_if.sink cfg_ch
);

	cfg_t cfg_q;
	entry_t smp;
	mem_req_t mem_req;
	entry_t mem_rd;
	res_t res;
	res_t res_q;
	logic res_vld_q;
	logic res_load;
	logic out_free;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ticks <= WINDOW_RESET;
			cfg_q.move_threshold <= THRESHOLD_RESET;
			cfg_q.click_min_ticks <= CLICK_MIN_RESET;
			cfg_q.click_max_ticks <= CLICK_MAX_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_WINDOW: cfg_q.window_ticks <= cfg_ch.data;
				REG_THRESHOLD: cfg_q.move_threshold <= cfg_ch.data[14:0];
				REG_CLICK_MIN: cfg_q.click_min_ticks <= cfg_ch.data;
				REG_CLICK_MAX: cfg_q.click_max_ticks <= cfg_ch.data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign smp.stamp = sample_ch.stamp;
	assign smp.pos_x = sample_ch.pos_x;
	assign smp.pos_y = sample_ch.pos_y;
	assign smp.grip = sample_ch.grip;

	hsc_window u_window (
		.clk(clk),
		.req(mem_req),
		.rd_data_q(mem_rd)
	);

	hsc_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.smp_valid(sample_ch.valid),
		.smp_ready(sample_ch.ready),
		.smp(smp),
		.mem_req(mem_req),
		.mem_rd(mem_rd),
		.out_free(out_free),
		.res_load(res_load),
		.res(res)
	);

	assign out_free = !res_vld_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_load) begin
			res_vld_q <= 1'b1;
		end else if (result_ch.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res;
	end

	assign result_ch.valid = res_vld_q;
	assign result_ch.direction = res_q.direction;
	assign result_ch.clicked = res_q.clicked;

endmodule
